/* hdl/sbus_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the SBUS frame decoder.
// No dependencies; used by every module under hdl/.
package sbus_pkg;

    localparam int unsigned CH_W        = 11;
    localparam int unsigned NUM_CH      = 16;
    localparam int unsigned PAYLOAD_LEN = 22;
    localparam int unsigned PAYLOAD_W   = PAYLOAD_LEN * 8;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned IDX_W       = 4;

    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE   = 8'h00;

    // byte position codes; payload occupies positions 1..22
    localparam logic [POS_W-1:0] POS_FIRST_DATA = 5'd1;
    localparam logic [POS_W-1:0] POS_LAST_DATA  = 5'd22;
    localparam logic [POS_W-1:0] POS_FLAGS      = 5'd23;
    localparam logic [POS_W-1:0] POS_END        = 5'd24;
    localparam logic [POS_W-1:0] POS_IDLE       = 5'd25;

    localparam logic [IDX_W-1:0] LAST_CH = 4'd15;

    // pulse map: 1000 + floor((v - 300) * 5 / 7), clamped to 1000..2000
    localparam logic [CH_W-1:0] RAW_OFFSET = 11'd300;
    localparam logic [11:0]     PULSE_MIN  = 12'd1000;
    localparam logic [11:0]     PULSE_MAX  = 12'd2000;
    // floor(x/7) == (x * 74899) >> 19 for all x below 14979
    localparam logic [16:0]     RECIP7     = 17'd74899;
    localparam int unsigned     RECIP_SH   = 19;

    // configuration register indexes
    localparam int unsigned      CFG_IDX_W     = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG_MASK  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_MAP  = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

endpackage

/* hdl/sbus_pulse_map.sv */
`timescale 1ns / 1ps
// Raw channel value to pulse width in microseconds; first stage registered.
// Depends on sbus_pkg.
module sbus_pulse_map (
    input  logic                        i_clk,
    input  logic                        i_load,
    input  logic [sbus_pkg::CH_W-1:0]   i_raw,
    output logic [sbus_pkg::CH_W-1:0]   o_pulse
);

    logic [13:0]                 r_x;
    logic                        r_low;
    logic [sbus_pkg::CH_W-1:0]   w_diff;
    logic [13:0]                 w_x5;
    logic [30:0]                 w_prod;
    logic [11:0]                 w_quot;
    logic [11:0]                 w_sum;
    logic [11:0]                 w_clamped;

    assign w_diff = i_raw - sbus_pkg::RAW_OFFSET;
    assign w_x5   = ({3'b000, w_diff} << 2) + {3'b000, w_diff};

    // stage 1: offset and scale by 5
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_low <= (i_raw < sbus_pkg::RAW_OFFSET);
            r_x   <= (i_raw < sbus_pkg::RAW_OFFSET) ? 14'd0 : w_x5;
        end
    end

    // stage 2: divide by 7 via reciprocal, add base, clamp
    assign w_prod = 31'(r_x) * 31'(sbus_pkg::RECIP7);
    assign w_quot = w_prod[30:sbus_pkg::RECIP_SH];
    assign w_sum  = sbus_pkg::PULSE_MIN + w_quot;

    always_comb begin
        if (r_low) begin
            w_clamped = sbus_pkg::PULSE_MIN;
        end else if (w_sum > sbus_pkg::PULSE_MAX) begin
            w_clamped = sbus_pkg::PULSE_MAX;
        end else begin
            w_clamped = w_sum;
        end
    end

    assign o_pulse = w_clamped[sbus_pkg::CH_W-1:0];

endmodule

/* hdl/sbus_frame_decoder.sv */
`timescale 1ns / 1ps
// SBUS 16-channel frame decoder top level.
// Depends on sbus_pkg and sbus_pulse_map.
//
//  channel | signals                                         | direction
//  --------+-------------------------------------------------+----------
//  input   | i_valid, o_ready, i_rx_byte, i_frame_first      | in
//  result  | o_valid, i_ready, o_frame_ok, o_channel_index,  | out
//          | o_channel_value, o_run_last                     |
//  config  | i_cfg_we, i_cfg_index, i_cfg_data               | in
//
// A byte that yields no result leaves the sequencer idle, so o_ready stays high.
// The end byte of a good frame starts a run of 16 results; each channel passes
// through ST_PREP (extract/scale), ST_MAP (map) and ST_OUT (present), while a
// rejection gives a single result. The single pulse-map unit and payload shifter set this.
// Reset is synchronous, active low; it clears the sequencer, the frame position
// (no frame in progress) and the config registers (raw mode, mask 0xFF).
// A stalled result holds all outputs; no input is taken while results are pending.
module sbus_frame_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [sbus_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [7:0]                          i_cfg_data,
    // byte input
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_rx_byte,
    input  logic                                i_frame_first,
    // results
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_frame_ok,
    output logic [sbus_pkg::IDX_W-1:0]          o_channel_index,
    output logic [sbus_pkg::CH_W-1:0]           o_channel_value,
    output logic                                o_run_last
);

    sbus_pkg::t_state                   r_state, n_state;
    logic [sbus_pkg::POS_W-1:0]         r_pos;
    logic                               r_start_good;
    logic                               r_flags_good;
    logic [sbus_pkg::PAYLOAD_W-1:0]     r_payload;
    logic [sbus_pkg::IDX_W-1:0]         r_ch;
    logic                               r_pulse_mode;
    logic [7:0]                         r_flag_mask;
    logic                               r_out_ok;
    logic [sbus_pkg::IDX_W-1:0]         r_out_idx;
    logic [sbus_pkg::CH_W-1:0]          r_out_val;
    logic                               r_out_last;

    logic                               w_in_xfer;
    logic                               w_out_xfer;
    logic                               w_at_end;
    logic                               w_frame_good;
    logic [sbus_pkg::CH_W-1:0]          w_raw;
    logic [sbus_pkg::CH_W-1:0]          w_pulse;

    assign o_ready    = (r_state == sbus_pkg::ST_IDLE);
    assign o_valid    = (r_state == sbus_pkg::ST_OUT);
    assign w_in_xfer  = i_valid && o_ready;
    assign w_out_xfer = o_valid && i_ready;

    // end byte of a frame in progress
    assign w_at_end     = w_in_xfer && !i_frame_first && (r_pos == sbus_pkg::POS_END);
    assign w_frame_good = r_start_good && r_flags_good && (i_rx_byte == sbus_pkg::END_BYTE);

    // current channel always sits in the low bits of the payload shifter
    assign w_raw = r_payload[sbus_pkg::CH_W-1:0];

    sbus_pulse_map u_map (
        .i_clk   (i_clk),
        .i_load  (r_state == sbus_pkg::ST_PREP),
        .i_raw   (w_raw),
        .o_pulse (w_pulse)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            sbus_pkg::ST_IDLE: begin
                if (w_at_end) begin
                    n_state = w_frame_good ? sbus_pkg::ST_PREP : sbus_pkg::ST_OUT;
                end
            end
            sbus_pkg::ST_PREP: n_state = sbus_pkg::ST_MAP;
            sbus_pkg::ST_MAP:  n_state = sbus_pkg::ST_OUT;
            sbus_pkg::ST_OUT: begin
                if (w_out_xfer) begin
                    n_state = r_out_last ? sbus_pkg::ST_IDLE : sbus_pkg::ST_PREP;
                end
            end
            default: n_state = sbus_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sbus_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_mode <= 1'b0;
            r_flag_mask  <= 8'hFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sbus_pkg::CFG_PULSE_MODE: r_pulse_mode <= i_cfg_data[0];
                sbus_pkg::CFG_FLAG_MASK:  r_flag_mask  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame position and checks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= sbus_pkg::POS_IDLE;
            r_start_good <= 1'b0;
            r_flags_good <= 1'b0;
        end else if (w_in_xfer) begin
            if (i_frame_first) begin
                r_start_good <= (i_rx_byte == sbus_pkg::START_BYTE);
                r_flags_good <= 1'b0;
                r_pos        <= sbus_pkg::POS_FIRST_DATA;
            end else if (r_pos == sbus_pkg::POS_FLAGS) begin
                r_flags_good <= ((i_rx_byte & r_flag_mask) == 8'h00);
                r_pos        <= r_pos + 5'd1;
            end else if (r_pos >= sbus_pkg::POS_FIRST_DATA &&
                         r_pos <= sbus_pkg::POS_LAST_DATA) begin
                r_pos <= r_pos + 5'd1;
            end else begin
                r_pos <= sbus_pkg::POS_IDLE;
            end
        end
    end

    // payload shifter: bytes enter at the top, channels leave at the bottom
    always_ff @(posedge i_clk) begin
        if (w_in_xfer && !i_frame_first &&
            r_pos >= sbus_pkg::POS_FIRST_DATA && r_pos <= sbus_pkg::POS_LAST_DATA) begin
            r_payload <= {i_rx_byte, r_payload[sbus_pkg::PAYLOAD_W-1:8]};
        end else if (w_out_xfer && !r_out_last) begin
            r_payload <= {{sbus_pkg::CH_W{1'b0}},
                          r_payload[sbus_pkg::PAYLOAD_W-1:sbus_pkg::CH_W]};
        end
    end

    // channel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (w_at_end) begin
            r_ch <= '0;
        end else if (w_out_xfer && !r_out_last) begin
            r_ch <= r_ch + 4'd1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_last <= 1'b0;
        end else if (w_at_end && !w_frame_good) begin
            r_out_last <= 1'b1;
        end else if (r_state == sbus_pkg::ST_MAP) begin
            r_out_last <= (r_ch == sbus_pkg::LAST_CH);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_at_end && !w_frame_good) begin
            r_out_ok  <= 1'b0;
            r_out_idx <= '0;
            r_out_val <= '0;
        end else if (r_state == sbus_pkg::ST_MAP) begin
            r_out_ok  <= 1'b1;
            r_out_idx <= r_ch;
            r_out_val <= r_pulse_mode ? w_pulse : w_raw;
        end
    end

    assign o_frame_ok      = r_out_ok;
    assign o_channel_index = r_out_idx;
    assign o_channel_value = r_out_val;
    assign o_run_last      = r_out_last;

endmodule

/* hdl/sbus_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for sbus_frame_decoder, with the bind that attaches them.
// Depends on sbus_pkg and the top-level port list.
module sbus_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_ready,
    input  logic                                o_valid,
    input  logic                                i_ready,
    input  logic                                o_frame_ok,
    input  logic [sbus_pkg::IDX_W-1:0]          o_channel_index,
    input  logic [sbus_pkg::CH_W-1:0]           o_channel_value,
    input  logic                                o_run_last
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_channel_value)
            && $stable(o_channel_index) && $stable(o_frame_ok) && $stable(o_run_last))
        else $error("result changed while stalled");

    // no byte is taken while results are pending
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input ready while result pending");

    // rejection result is a single all-zero last result
    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_frame_ok |-> o_run_last && o_channel_index == '0
            && o_channel_value == '0)
        else $error("malformed rejection result");

    // a good run ends on the last channel
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_ok |-> (o_run_last == (o_channel_index == sbus_pkg::LAST_CH)))
        else $error("run end mismatch");

    // mid-run transfer keeps the input side closed
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_run_last |=> !o_ready)
        else $error("input reopened inside a run");

endmodule

bind sbus_frame_decoder sbus_checker u_sbus_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_frame_ok      (o_frame_ok),
    .o_channel_index (o_channel_index),
    .o_channel_value (o_channel_value),
    .o_run_last      (o_run_last)
);

/* tb/sbus_frame_decoder_checker.sv */
`timescale 1ns / 1ps
// Result checker for sbus_frame_decoder: mirrors the frame decode on each byte
// transfer and compares every result transfer field by field. Depends on sbus_pkg.
module sbus_frame_decoder_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [sbus_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_frame_first,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic                           i_frame_ok,
    input  logic [sbus_pkg::IDX_W-1:0]     i_channel_index,
    input  logic [sbus_pkg::CH_W-1:0]      i_channel_value,
    input  logic                           i_run_last,
    output int                             o_fail_count,
    output int                             o_pending
);
    import sbus_pkg::*;

    typedef struct packed {
        logic             frame_ok;
        logic [IDX_W-1:0] index;
        logic [CH_W-1:0]  value;
        logic             run_last;
    } chan_word_t;

    chan_word_t       pending_channels[$];

    logic [POS_W-1:0] frame_pos;
    logic             start_seen_ok;
    logic             flags_seen_ok;
    logic [7:0]       payload_bytes[PAYLOAD_LEN];
    logic             pulse_mode_q;
    logic [7:0]       reject_mask_q;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [CH_W-1:0] pulse_width_us(input logic [CH_W-1:0] raw);
        int unsigned v;
        int unsigned w;
        v = {21'd0, raw};
        if (v < 300) begin
            return 11'd1000;
        end
        w = 1000 + ((v - 300) * 5) / 7;
        if (w > 2000) begin
            w = 2000;
        end
        return w[CH_W-1:0];
    endfunction

    task automatic report(input string field, input int want, input int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
        o_fail_count++;
    endtask

    // One byte transfer: advance the frame position, judge the frame on the end byte.
    task automatic decode_byte(input logic [7:0] b, input logic first);
        logic [PAYLOAD_W-1:0] bits;
        logic [CH_W-1:0]      raw;
        chan_word_t           word;
        if (first) begin
            start_seen_ok = (b == START_BYTE);
            flags_seen_ok = 1'b0;
            frame_pos     = POS_FIRST_DATA;
        end else if (frame_pos >= POS_IDLE) begin
            // no frame open: byte dropped
        end else if (frame_pos <= POS_LAST_DATA) begin
            payload_bytes[frame_pos - POS_FIRST_DATA] = b;
            frame_pos++;
        end else if (frame_pos == POS_FLAGS) begin
            flags_seen_ok = ((b & reject_mask_q) == 8'h00);
            frame_pos++;
        end else begin
            frame_pos = POS_IDLE;
            if (!(start_seen_ok && flags_seen_ok && b == END_BYTE)) begin
                word = '{frame_ok: 1'b0, index: '0, value: '0, run_last: 1'b1};
                pending_channels.push_back(word);
            end else begin
                for (int i = 0; i < PAYLOAD_LEN; i++) begin
                    bits[8*i +: 8] = payload_bytes[i];
                end
                for (int c = 0; c < NUM_CH; c++) begin
                    raw = bits[CH_W*c +: CH_W];
                    word.frame_ok = 1'b1;
                    word.index    = c[IDX_W-1:0];
                    word.value    = pulse_mode_q ? pulse_width_us(raw) : raw;
                    word.run_last = (c == NUM_CH - 1);
                    pending_channels.push_back(word);
                end
            end
        end
    endtask

    task automatic check_result();
        chan_word_t want;
        if (pending_channels.size() == 0) begin
            report("unexpected result, channel_value", -1, int'(i_channel_value));
        end else begin
            want = pending_channels.pop_front();
            if (i_frame_ok !== want.frame_ok) begin
                report("frame_ok", int'(want.frame_ok), int'(i_frame_ok));
            end
            if (i_channel_index !== want.index) begin
                report("channel_index", int'(want.index), int'(i_channel_index));
            end
            if (i_channel_value !== want.value) begin
                report("channel_value", int'(want.value), int'(i_channel_value));
            end
            if (i_run_last !== want.run_last) begin
                report("run_last", int'(want.run_last), int'(i_run_last));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos     = POS_IDLE;
            start_seen_ok = 1'b0;
            flags_seen_ok = 1'b0;
            pulse_mode_q  = 1'b0;
            reject_mask_q = 8'hFF;
            pending_channels.delete();
        end else begin
            // results leave before this edge's byte can add any
            if (i_out_valid && i_out_ready) begin
                check_result();
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PULSE_MODE: pulse_mode_q = i_cfg_data[0];
                    CFG_FLAG_MASK:  reject_mask_q = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                decode_byte(i_rx_byte, i_frame_first);
            end
        end
        o_pending = pending_channels.size();
    end

endmodule

/* tb/sbus_frame_decoder_tb.sv */
`timescale 1ns / 1ps
// Testbench top for sbus_frame_decoder: byte and result traffic, register
// settings and the verdict. Depends on sbus_pkg and sbus_frame_decoder_checker.
module sbus_frame_decoder_tb;
    import sbus_pkg::*;

    localparam int FRAME_BYTES   = 25;
    localparam int HOLD_CYCLES   = 400;   // long result stall, lets the decoder back up
    localparam int SETTLE_CYCLES = 8;     // margin for a last no-result byte
    localparam int DRAIN_CYCLES  = 64;    // drain margin after a full run of 16 channels

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [7:0]           i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [7:0]           i_rx_byte;
    logic                 i_frame_first;
    logic                 o_valid;
    logic                 i_ready;
    logic                 o_frame_ok;
    logic [IDX_W-1:0]     o_channel_index;
    logic [CH_W-1:0]      o_channel_value;
    logic                 o_run_last;

    int fail_count;
    int pending;

    // idle chances in percent, set per phase by the stimulus process
    int send_idle_pct = 10;
    int recv_idle_pct = 63;

    // long receiver stalls: the stimulus asks, the receiver process counts them out
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    // raw values around the pulse map corners: below/at the 300 offset,
    // the 7-step rounding, the 2000 clamp at 1700 and the 11-bit top
    logic [CH_W-1:0] probe_vals[NUM_CH] = '{
        11'd0, 11'd299, 11'd300, 11'd301, 11'd306, 11'd307, 11'd1000, 11'd1023,
        11'd1024, 11'd1699, 11'd1700, 11'd1701, 11'd1702, 11'd2046, 11'd2047, 11'd1
    };

    sbus_frame_decoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_rx_byte       (i_rx_byte),
        .i_frame_first   (i_frame_first),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_ok      (o_frame_ok),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_run_last      (o_run_last)
    );

    sbus_frame_decoder_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_rx_byte       (i_rx_byte),
        .i_frame_first   (i_frame_first),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_frame_ok      (o_frame_ok),
        .i_channel_index (o_channel_index),
        .i_channel_value (o_channel_value),
        .i_run_last      (o_run_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: reports failure and stops a run that hangs.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side. Random stalls at recv_idle_pct, plus a long hold on request.
    // i_ready gets exactly one nonblocking write per edge.
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (holds_served != hold_requests) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // One byte transfer. Random gaps come first, then valid is held with a
    // steady payload until the edge where o_ready is seen high.
    task automatic send_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_frame_first <= first;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Sends the first `keep` bytes of a frame: start, 22 payload, flags, end.
    // keep below 25 leaves the frame open so the next start cuts it short.
    task automatic send_frame(input logic [7:0] start_b, input logic [PAYLOAD_W-1:0] data,
                              input logic [7:0] flags_b, input logic [7:0] end_b,
                              input int keep);
        logic [7:0] b;
        for (int k = 0; k < keep; k++) begin
            if (k == 0) begin
                b = start_b;
            end else if (k <= PAYLOAD_LEN) begin
                b = data[8*(k-1) +: 8];
            end else if (k == POS_FLAGS) begin
                b = flags_b;
            end else begin
                b = end_b;
            end
            send_byte(b, k == 0);
        end
    endtask

    function automatic logic [PAYLOAD_W-1:0] random_payload();
        logic [PAYLOAD_W-1:0] data;
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            data[8*i +: 8] = 8'($urandom_range(255));
        end
        return data;
    endfunction

    // Waits until every expected result has come out, then a few cycles more
    // in case a last no-result byte is still being absorbed.
    task automatic settle();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic pulse, input logic [7:0] mask);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PULSE_MODE;
        i_cfg_data  <= {7'd0, pulse};
        @(posedge i_clk);
        i_cfg_index <= CFG_FLAG_MASK;
        i_cfg_data  <= mask;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [PAYLOAD_W-1:0] probe_data;
        logic [7:0]           part_mask;
        for (int c = 0; c < NUM_CH; c++) begin
            probe_data[CH_W*c +: CH_W] = probe_vals[c];
        end

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_PULSE_MODE;
        i_cfg_data    <= 8'h00;
        i_valid       <= 1'b0;
        i_rx_byte     <= 8'h00;
        i_frame_first <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- reset settings: raw values, mask 0xFF; sender fast, receiver slow ----
        send_byte(8'hA5, 1'b0);                                             // no frame open yet
        send_frame(START_BYTE, random_payload(), 8'h00, END_BYTE, 7);       // cut by next start
        send_frame(START_BYTE, random_payload(), 8'h00, END_BYTE, FRAME_BYTES);
        send_frame(START_BYTE, random_payload(), 8'h01, END_BYTE, FRAME_BYTES); // flag reject

        // ---- pulse widths with nothing masked; sender slow, receiver fast ----
        settle();
        send_idle_pct = 63;
        recv_idle_pct = 10;
        apply_settings(1'b1, 8'h00);
        // receiver goes quiet while the probe frame ends: the next frame has
        // to wait at the input until the run of channels drains
        hold_requests++;
        send_frame(START_BYTE, probe_data, 8'hFF, END_BYTE, FRAME_BYTES);
        send_frame(START_BYTE, '1, 8'h00, END_BYTE, 4);                     // left open

        // ---- raw values, random partial mask, no idling on either side ----
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        part_mask = 8'($urandom_range(1, 254));
        apply_settings(1'b0, part_mask);
        send_frame(START_BYTE, random_payload(), 8'($urandom_range(255)) & ~part_mask,
                   END_BYTE, FRAME_BYTES);

        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/sbus_pkg.sv
hdl/sbus_pulse_map.sv
hdl/sbus_frame_decoder.sv
hdl/sbus_checker.sv
tb/sbus_frame_decoder_checker.sv
tb/sbus_frame_decoder_tb.sv
